/* rtl/core/llm_pkg.sv */
// shared types, constants and helpers for the lease lock manager
package llm_pkg;

  localparam int unsigned DEF_MAX_LOCKS   = 64;
  localparam int unsigned DEF_MAX_CLIENTS = 16;
  localparam int unsigned CFG_W           = 32;
  localparam int unsigned CFG_IDX_W       = 2;
  localparam int unsigned TIME_W          = 48;
  localparam int unsigned STAMP_W         = 32;
  localparam int unsigned CLIENT_W        = 4;
  localparam int unsigned LOCK_W          = 6;

  localparam logic [CFG_IDX_W-1:0] REG_CLIENT_COUNT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOCK_COUNT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_LEASE = 2'd2;

  localparam logic [4:0]  CLIENT_COUNT_RST  = 5'd16;
  localparam logic [6:0]  LOCK_COUNT_RST    = 7'd64;
  localparam logic [31:0] DEFAULT_LEASE_RST = 32'd5000;

  localparam logic [2:0] OP_ACQUIRE = 3'd0;
  localparam logic [2:0] OP_RELEASE = 3'd1;
  localparam logic [2:0] OP_RENEW   = 3'd2;
  localparam logic [2:0] OP_TICK    = 3'd3;
  localparam logic [2:0] OP_QUERY   = 3'd4;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_RANGE     = 2'd1;
  localparam logic [1:0] ST_HELD      = 2'd2;
  localparam logic [1:0] ST_NOT_OWNER = 2'd3;

  typedef struct packed {
    logic [2:0]  operation;
    logic [3:0]  client;
    logic [5:0]  lock_index;
    logic [31:0] duration;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        locked;
    logic [3:0]  owner;
    logic [31:0] grant_stamp;
  } rsp_t;

  // classified command handed from front to back
  typedef struct packed {
    logic        bad;
    logic [2:0]  operation;
    logic [3:0]  client;
    logic [5:0]  lock_index;
    logic [31:0] ttl;
  } cmd_t;

  function automatic logic [TIME_W-1:0] add_sat48(input logic [TIME_W-1:0] a,
                                                   input logic [31:0] b);
    logic [TIME_W:0] s;
    s = {1'b0, a} + {17'd0, b};
    return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
  endfunction

endpackage

/* rtl/core/lease_lock_manager.sv */
// top level of the lease lock manager
// usage:
//   requests enter on req with push; full high means no item is taken.
//   results leave on rsp; while empty is low the oldest result waits and
//   pop takes it. configuration is written by cfg_we/cfg_index/cfg_data,
//   and the user must do so while no item is in flight (not enforced).
// result path:
//   with the back end free, an item taken from the queue has its table
//   entries read as it reaches the back end; in EXEC the table is updated
//   and the result loaded. a tick sweeps one lock per cycle and its
//   result is loaded once the sweep has passed the lock count in use.
//   the back end takes the next item only after the result is popped, so
//   it never starts an item before the last one's result has left.
// reset:
//   rst (synchronous) frees all locks, clears clocks and time, and sets
//   the registers to 16 clients, 64 locks and a 5000 ms default lease.
// stall:
//   while a result is not popped the back end holds; the two-entry queue
//   fills and then full rises.
module lease_lock_manager #(
  parameter int unsigned MAX_LOCKS   = llm_pkg::DEF_MAX_LOCKS,
  parameter int unsigned MAX_CLIENTS = llm_pkg::DEF_MAX_CLIENTS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  output logic                              full,
  input  llm_pkg::req_t                     req,
  output logic                              empty,
  input  logic                              pop,
  output llm_pkg::rsp_t                     rsp,
  input  logic                              cfg_we,
  input  logic [llm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [llm_pkg::CFG_W-1:0]         cfg_data
);
  import llm_pkg::*;

  logic [4:0]  num_clients;
  logic [6:0]  num_locks;
  logic [31:0] default_lease;
  logic        cmd_valid, cmd_take;
  cmd_t        cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_clients   <= CLIENT_COUNT_RST;
      num_locks     <= LOCK_COUNT_RST;
      default_lease <= DEFAULT_LEASE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CLIENT_COUNT:  num_clients   <= cfg_data[4:0];
        REG_LOCK_COUNT:    num_locks     <= cfg_data[6:0];
        REG_DEFAULT_LEASE: default_lease <= cfg_data;
        default: ;
      endcase
    end
  end

  llm_front #(.MAX_LOCKS(MAX_LOCKS), .MAX_CLIENTS(MAX_CLIENTS)) u_front (
    .clk, .rst, .push, .full, .req, .num_clients, .num_locks,
    .default_lease, .cmd_valid, .cmd_take, .cmd
  );

  llm_back #(.MAX_LOCKS(MAX_LOCKS), .MAX_CLIENTS(MAX_CLIENTS)) u_back (
    .clk, .rst, .cmd_valid, .cmd_take, .cmd, .num_locks, .empty, .pop, .rsp
  );

  a_take_needs_space: assert property (@(posedge clk) disable iff (rst)
    cmd_take |-> empty) else $error("command taken while result waits");
  a_held_on_stall: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> !empty) else $error("result dropped");
  a_range_status: assert property (@(posedge clk) disable iff (rst)
    (!empty && rsp.locked) |-> rsp.status == ST_OK) else $error("bad locked");
endmodule

/* rtl/core/llm_front.sv */
// front end: range checks, lease defaulting and command queue
module llm_front #(
  parameter int unsigned MAX_LOCKS   = llm_pkg::DEF_MAX_LOCKS,
  parameter int unsigned MAX_CLIENTS = llm_pkg::DEF_MAX_CLIENTS
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  output logic          full,
  input  llm_pkg::req_t req,
  input  logic [4:0]    num_clients,
  input  logic [6:0]    num_locks,
  input  logic [31:0]   default_lease,
  output logic          cmd_valid,
  input  logic          cmd_take,
  output llm_pkg::cmd_t cmd
);
  import llm_pkg::*;

  cmd_t       q [2];
  logic [1:0] cnt;
  logic       wp, rp;
  logic [8:0] eff_cl;
  logic [10:0] eff_lk;
  logic       cl_bad, lk_bad, do_push, do_pop;
  cmd_t       c_in;

  always_comb begin
    eff_cl = ({4'd0, num_clients} > 9'(MAX_CLIENTS)) ? 9'(MAX_CLIENTS)
                                                     : {4'd0, num_clients};
    eff_lk = ({4'd0, num_locks} > 11'(MAX_LOCKS)) ? 11'(MAX_LOCKS)
                                                  : {4'd0, num_locks};
    cl_bad = {5'd0, req.client} >= eff_cl;
    lk_bad = {5'd0, req.lock_index} >= eff_lk;
    c_in.operation  = req.operation;
    c_in.client     = req.client;
    c_in.lock_index = req.lock_index;
    c_in.ttl        = (req.duration != '0 || req.operation == OP_TICK)
                      ? req.duration : default_lease;
    case (req.operation)
      OP_ACQUIRE, OP_RELEASE, OP_RENEW: c_in.bad = cl_bad | lk_bad;
      OP_TICK:  c_in.bad = 1'b0;
      OP_QUERY: c_in.bad = lk_bad;
      default:  c_in.bad = 1'b1;
    endcase
  end

  assign full      = cnt[1];
  assign cmd_valid = cnt != 2'd0;
  assign cmd       = q[rp];
  assign do_push   = push && !full;
  assign do_pop    = cmd_take && cmd_valid;

  always_ff @(posedge clk) begin
    if (do_push) q[wp] <= c_in;
    if (rst) begin
      cnt <= '0;
      wp  <= 1'b0;
      rp  <= 1'b0;
    end else begin
      if (do_push) wp <= ~wp;
      if (do_pop)  rp <= ~rp;
      cnt <= cnt + {1'b0, do_push} - {1'b0, do_pop};
    end
  end
endmodule

/* rtl/core/llm_back.sv */
// back end: lock table, clocks, tick sweep and result register
module llm_back #(
  parameter int unsigned MAX_LOCKS   = llm_pkg::DEF_MAX_LOCKS,
  parameter int unsigned MAX_CLIENTS = llm_pkg::DEF_MAX_CLIENTS
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_take,
  input  llm_pkg::cmd_t cmd,
  input  logic [6:0]    num_locks,
  output logic          empty,
  input  logic          pop,
  output llm_pkg::rsp_t rsp
);
  import llm_pkg::*;

  localparam int unsigned LW = (MAX_LOCKS > 1) ? $clog2(MAX_LOCKS) : 1;
  localparam int unsigned CW = (MAX_CLIENTS > 1) ? $clog2(MAX_CLIENTS) : 1;

  typedef enum logic [1:0] {IDLE, EXEC, SWEEP} state_t;

  logic [MAX_LOCKS-1:0] granted;
  logic [3:0]           owner_mem  [MAX_LOCKS];
  logic [TIME_W-1:0]    expiry_mem [MAX_LOCKS];
  logic [31:0]          cclock     [MAX_CLIENTS];
  logic [31:0]          gclock;
  logic [TIME_W-1:0]    now_ms;

  state_t     state;
  cmd_t       cur;
  logic [3:0] rd_owner;
  logic [TIME_W-1:0] rd_exp;
  logic [31:0] rd_cclk;
  logic [10:0] sw_idx, eff_lk;
  logic [LW-1:0] sw_prev;
  logic        sw_chk;
  logic        out_full;
  logic [LW-1:0] li, si;
  logic [CW-1:0] ci;
  logic [31:0]  gmax, gnext;
  logic [TIME_W-1:0] new_exp;
  logic        live, mine, held;
  rsp_t        res;

  assign li = LW'(cur.lock_index);
  assign ci = CW'(cur.client);
  assign si = sw_idx[LW-1:0];
  assign eff_lk = ({4'd0, num_locks} > 11'(MAX_LOCKS)) ? 11'(MAX_LOCKS)
                                                       : {4'd0, num_locks};
  assign cmd_take = state == IDLE && cmd_valid && !out_full;
  assign empty = !out_full;

  always_comb begin
    gmax    = (rd_cclk > gclock) ? rd_cclk : gclock;
    gnext   = (gmax != '1) ? gmax + 32'd1 : gmax;
    new_exp = add_sat48(now_ms, cur.ttl);
    live    = granted[li] && now_ms < rd_exp;
    mine    = granted[li] && rd_owner == cur.client;
    held    = live && rd_owner != cur.client;
    res     = '0;
    if (cur.bad) begin
      res.status = ST_RANGE;
    end else begin
      case (cur.operation)
        OP_ACQUIRE: begin
          if (held) res.status = ST_HELD;
          else res.grant_stamp = gnext;
        end
        OP_RELEASE, OP_RENEW: begin
          if (!mine) res.status = ST_NOT_OWNER;
        end
        OP_TICK: ;
        OP_QUERY: begin
          if (live) begin
            res.locked = 1'b1;
            res.owner  = rd_owner;
          end
        end
        default: res.status = ST_RANGE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_take) begin
      cur      <= cmd;
      rd_owner <= owner_mem[LW'(cmd.lock_index)];
      rd_exp   <= expiry_mem[LW'(cmd.lock_index)];
      rd_cclk  <= cclock[CW'(cmd.client)];
    end
    if (state == EXEC && !cur.bad && !rst) begin
      if (cur.operation == OP_ACQUIRE && !held) begin
        owner_mem[li]  <= cur.client;
        expiry_mem[li] <= new_exp;
        cclock[ci]     <= gnext;
      end else if (cur.operation == OP_RELEASE && mine) begin
        owner_mem[li] <= '0;
      end else if (cur.operation == OP_RENEW && mine) begin
        expiry_mem[li] <= new_exp;
      end
    end
    if (rst) begin
      state    <= IDLE;
      granted  <= '0;
      gclock   <= '0;
      now_ms   <= '0;
      out_full <= 1'b0;
      sw_idx   <= '0;
      sw_prev  <= '0;
      sw_chk   <= 1'b0;
      for (int i = 0; i < MAX_CLIENTS; i++) cclock[i] <= '0;
    end else begin
      if (pop && out_full) out_full <= 1'b0;
      case (state)
        IDLE: begin
          if (cmd_take) state <= EXEC;
        end
        EXEC: begin
          if (!cur.bad && cur.operation == OP_TICK) begin
            now_ms <= new_exp;
            sw_idx <= '0;
            sw_chk <= 1'b0;
            state  <= SWEEP;
          end else begin
            rsp      <= res;
            out_full <= 1'b1;
            state    <= IDLE;
          end
          if (!cur.bad && cur.operation == OP_ACQUIRE) begin
            gclock <= gnext;
            if (!held) granted[li] <= 1'b1;
          end
          if (!cur.bad && cur.operation == OP_RELEASE && mine) granted[li] <= 1'b0;
        end
        SWEEP: begin
          // one lock per cycle; expiry is registered in rd_exp and checked the cycle after
          if (sw_chk && granted[sw_prev] && now_ms >= rd_exp) begin
            granted[sw_prev]   <= 1'b0;
            owner_mem[sw_prev] <= '0;
          end
          if (sw_idx >= eff_lk) begin
            sw_chk   <= 1'b0;
            rsp      <= '0;
            out_full <= 1'b1;
            state    <= IDLE;
          end else begin
            rd_exp  <= expiry_mem[si];
            sw_prev <= si;
            sw_chk  <= 1'b1;
            sw_idx  <= sw_idx + 11'd1;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end
endmodule

/* test/tb_lease_lock_manager.sv */
// testbench for the lease lock manager: directed table, random traffic, scoreboard check
module tb_lease_lock_manager;
  import llm_pkg::*;

  localparam int NLOCK = 64;
  localparam int NCLI = 16;
  localparam longint unsigned T_MAX = 48'hFFFFFFFFFFFF;
  localparam int CYCLE_LIMIT = 2000000;

  typedef struct packed {
    logic [2:0]  op;
    logic [3:0]  cl;
    logic [5:0]  lk;
    logic [31:0] dur;
    logic        typed;
    rsp_t        want;
  } row_t;

  logic clk, rst, push, full, empty, pop, cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;
  req_t req;
  rsp_t rsp;

  lease_lock_manager dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .req(req), .empty(empty),
    .pop(pop), .rsp(rsp), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // predictor state
  bit               granted [NLOCK];
  logic [3:0]       holder [NLOCK];
  longint unsigned  expiry [NLOCK];
  logic [31:0]      cli_clk [NCLI];
  logic [31:0]      gclk;
  longint unsigned  now;
  logic [4:0]       n_clients;
  logic [6:0]       n_locks;
  logic [31:0]      dflt_lease;

  rsp_t pending_rsp[$];
  int errors, cycles;
  int send_idle, recv_idle;
  bit hold_off;

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout");
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic report(input string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  function automatic longint unsigned sat_add(longint unsigned a, logic [31:0] b);
    longint unsigned s;
    s = a + longint'(b);
    return s > T_MAX ? T_MAX : s;
  endfunction

  function automatic rsp_t lease_predict(req_t r);
    rsp_t o;
    int nc, nl;
    logic [31:0] ttl;
    longint unsigned g;
    o = '0;
    nc = n_clients > NCLI ? NCLI : n_clients;
    nl = n_locks > NLOCK ? NLOCK : n_locks;
    ttl = r.duration != 0 ? r.duration : dflt_lease;
    case (r.operation)
      OP_ACQUIRE, OP_RELEASE, OP_RENEW: begin
        if (r.client >= nc || r.lock_index >= nl) o.status = ST_RANGE;
        else if (r.operation == OP_ACQUIRE) begin
          g = gclk;
          if (cli_clk[r.client] > g) g = cli_clk[r.client];
          if (g < 32'hFFFFFFFF) g++;
          gclk = g[31:0];
          if (granted[r.lock_index] && holder[r.lock_index] != r.client
              && now < expiry[r.lock_index]) o.status = ST_HELD;
          else begin
            granted[r.lock_index] = 1;
            holder[r.lock_index] = r.client;
            expiry[r.lock_index] = sat_add(now, ttl);
            cli_clk[r.client] = gclk;
            o.grant_stamp = gclk;
          end
        end else if (!granted[r.lock_index] || holder[r.lock_index] != r.client)
          o.status = ST_NOT_OWNER;
        else if (r.operation == OP_RELEASE) begin
          granted[r.lock_index] = 0;
          holder[r.lock_index] = 0;
        end else expiry[r.lock_index] = sat_add(now, ttl);
      end
      OP_TICK: begin
        now = sat_add(now, r.duration);
        for (int k = 0; k < nl; k++)
          if (granted[k] && now >= expiry[k]) begin
            granted[k] = 0;
            holder[k] = 0;
          end
      end
      OP_QUERY: begin
        if (r.lock_index >= nl) o.status = ST_RANGE;
        else if (granted[r.lock_index] && now < expiry[r.lock_index]) begin
          o.locked = 1;
          o.owner = holder[r.lock_index];
        end
      end
      default: o.status = ST_RANGE;
    endcase
    return o;
  endfunction

  // result checker and receiver stalls
  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      if (pending_rsp.size() == 0) begin
        report("unexpected result");
      end else begin
        rsp_t w;
        w = pending_rsp.pop_front();
        if (rsp.status !== w.status)
          report($sformatf("status got %0d want %0d", rsp.status, w.status));
        if (rsp.locked !== w.locked)
          report($sformatf("locked got %0d want %0d", rsp.locked, w.locked));
        if (rsp.owner !== w.owner)
          report($sformatf("owner got %0d want %0d", rsp.owner, w.owner));
        if (rsp.grant_stamp !== w.grant_stamp)
          report($sformatf("grant_stamp got %0d want %0d", rsp.grant_stamp,
                           w.grant_stamp));
      end
    end
  end

  always @(negedge clk)
    pop <= !hold_off && ($urandom_range(99) >= recv_idle);

  task automatic send(req_t r, bit typed, rsp_t want);
    rsp_t p;
    while ($urandom_range(99) < send_idle) begin
      push <= 0;
      @(negedge clk);
    end
    push <= 1;
    req <= r;
    @(posedge clk);
    while (full) @(posedge clk);
    p = lease_predict(r);
    if (typed && p !== want)
      report($sformatf("table row disagrees with predictor for op %0d", r.operation));
    pending_rsp.push_back(typed ? want : p);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    case (idx)
      REG_CLIENT_COUNT: n_clients = val[4:0];
      REG_LOCK_COUNT: n_locks = val[6:0];
      default: dflt_lease = val;
    endcase
  endtask

  task automatic set_regs(logic [31:0] v_cl, logic [31:0] v_lk, logic [31:0] v_lease);
    write_reg(REG_CLIENT_COUNT, v_cl);
    write_reg(REG_LOCK_COUNT, v_lk);
    write_reg(REG_DEFAULT_LEASE, v_lease);
    cfg_we <= 0;
  endtask

  task automatic drain;
    int t;
    push <= 0;
    t = 0;
    while (pending_rsp.size() != 0 && t < 200000) begin
      @(negedge clk);
      t++;
    end
    repeat (NLOCK + 20) @(negedge clk);
  endtask

  function automatic req_t make_req(logic [2:0] op, logic [3:0] cl, logic [5:0] lk,
                                    logic [31:0] d);
    req_t r;
    r.operation = op;
    r.client = cl;
    r.lock_index = lk;
    r.duration = d;
    return r;
  endfunction

  function automatic rsp_t mk(logic [1:0] s, logic l, logic [3:0] o, logic [31:0] g);
    rsp_t r;
    r.status = s;
    r.locked = l;
    r.owner = o;
    r.grant_stamp = g;
    return r;
  endfunction

  row_t dir_tab[$];

  task automatic random_phase(int count, int lim_cl, int lim_lk);
    req_t r;
    int pick;
    logic [31:0] d;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      case ($urandom_range(9))
        0: d = 0;
        1: d = 32'hFFFFFFFF;
        2: d = $urandom;
        default: d = $urandom_range(300);
      endcase
      if (pick < 40) r = make_req(OP_ACQUIRE, 0, 0, d);
      else if (pick < 52) r = make_req(OP_RELEASE, 0, 0, d);
      else if (pick < 64) r = make_req(OP_RENEW, 0, 0, d);
      else if (pick < 76) r = make_req(OP_TICK, 0, 0, $urandom_range(1) ? $urandom_range(200) : d);
      else if (pick < 96) r = make_req(OP_QUERY, 0, 0, d);
      else r = make_req(3'($urandom_range(7)), 0, 0, d);
      if ($urandom_range(9) == 0) begin
        r.client = 4'($urandom);
        r.lock_index = 6'($urandom);
      end else begin
        r.client = 4'($urandom_range(lim_cl - 1));
        r.lock_index = 6'($urandom_range(lim_lk - 1));
      end
      send(r, 0, '0);
    end
  endtask

  initial begin
    row_t w;
    rst = 1; push = 0; pop = 0; cfg_we = 0; cfg_index = '0; cfg_data = '0; req = '0;
    errors = 0; cycles = 0; send_idle = 0; recv_idle = 0; hold_off = 0;
    foreach (granted[k]) begin granted[k] = 0; holder[k] = 0; expiry[k] = 0; end
    foreach (cli_clk[c]) cli_clk[c] = 0;
    gclk = 0; now = 0;
    n_clients = CLIENT_COUNT_RST; n_locks = LOCK_COUNT_RST; dflt_lease = DEFAULT_LEASE_RST;
    repeat (7) @(negedge clk);
    rst = 0;

    // op, client, lock, duration, typed, expected
    dir_tab = '{
      '{OP_QUERY,   4'd0,  6'd0,  32'd0,          1, mk(ST_OK, 0, 0, 0)},
      '{OP_ACQUIRE, 4'd0,  6'd0,  32'd0,          1, mk(ST_OK, 0, 0, 1)},
      '{OP_ACQUIRE, 4'd15, 6'd63, 32'hFFFFFFFF,   1, mk(ST_OK, 0, 0, 2)},
      '{OP_QUERY,   4'd0,  6'd63, 32'd0,          1, mk(ST_OK, 1, 15, 0)},
      '{OP_ACQUIRE, 4'd3,  6'd0,  32'd10,         1, mk(ST_HELD, 0, 0, 0)},
      '{OP_RELEASE, 4'd3,  6'd0,  32'd0,          1, mk(ST_NOT_OWNER, 0, 0, 0)},
      '{OP_RENEW,   4'd0,  6'd0,  32'd1,          0, '0},
      '{OP_ACQUIRE, 4'd5,  6'd7,  32'd0,          0, '0},
      '{OP_TICK,    4'd0,  6'd0,  32'd1,          1, mk(ST_OK, 0, 0, 0)},
      '{OP_QUERY,   4'd0,  6'd0,  32'd0,          0, '0},
      '{OP_RENEW,   4'd0,  6'd0,  32'd5,          0, '0},
      '{OP_TICK,    4'd0,  6'd0,  32'hFFFFFFFF,   0, '0},
      '{OP_QUERY,   4'd0,  6'd63, 32'd0,          0, '0},
      '{OP_TICK,    4'd0,  6'd0,  32'hFFFFFFFF,   0, '0},
      '{OP_RELEASE, 4'd15, 6'd63, 32'd0,          0, '0},
      '{OP_RELEASE, 4'd5,  6'd7,  32'd0,          0, '0},
      '{3'd5,       4'd1,  6'd1,  32'd1,          1, mk(ST_RANGE, 0, 0, 0)},
      '{3'd7,       4'd15, 6'd63, 32'hFFFFFFFF,   1, mk(ST_RANGE, 0, 0, 0)},
      '{OP_ACQUIRE, 4'd9,  6'd20, 32'hFFFFFFFF,   0, '0},
      '{OP_QUERY,   4'd0,  6'd20, 32'd0,          0, '0}
    };
    foreach (dir_tab[i]) begin
      w = dir_tab[i];
      send(make_req(w.op, w.cl, w.lk, w.dur), w.typed, w.want);
    end
    drain();

    // small table: range errors, zero lease, long receiver hold-off
    set_regs(3, 4, 0);
    send(make_req(OP_ACQUIRE, 4'd3, 6'd0, 0), 1, mk(ST_RANGE, 0, 0, 0));
    send(make_req(OP_QUERY, 4'd0, 6'd4, 0), 1, mk(ST_RANGE, 0, 0, 0));
    send(make_req(OP_RENEW, 4'd0, 6'd9, 0), 1, mk(ST_RANGE, 0, 0, 0));
    fork
      begin
        hold_off = 1;
        repeat (150) @(negedge clk);
        hold_off = 0;
      end
      random_phase(40, 4, 6);
    join
    random_phase(260, 4, 6);
    drain();

    set_regs(0, 0, 32'hFFFFFFFF);
    random_phase(40, 16, 64);
    drain();

    set_regs(31, 127, 1);
    send_idle = 64;
    random_phase(300, 16, 64);
    drain();

    set_regs(16, 8, 120);
    send_idle = 0; recv_idle = 64;
    random_phase(450, 16, 10);
    drain();

    set_regs(1, 64, 50);
    send_idle = 20; recv_idle = 20;
    random_phase(300, 2, 64);
    drain();

    set_regs(5, 16, 5000);
    send_idle = 0; recv_idle = 0;
    random_phase(520, 6, 18);
    drain();

    if (errors == 0 && pending_rsp.size() == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end
endmodule

/* filelist.f */
rtl/core/llm_pkg.sv
rtl/core/llm_front.sv
rtl/core/llm_back.sv
rtl/core/lease_lock_manager.sv
test/tb_lease_lock_manager.sv
